// File: hw/rtl/ira_pkg.sv
// Shared types, constants and the digit-to-character function for the
// integer to radix ASCII converter. No dependencies.

package ira_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int IDX_W      = $clog2(VALUE_BITS);
  localparam int RADIX_W    = 6;

  localparam logic [RADIX_W-1:0] MIN_RADIX     = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] MAX_RADIX     = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DEFAULT_RADIX = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] DIGIT_TEN     = RADIX_W'(10);

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]           base;
    logic                         upper_case;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_beat_t;

  function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d,
                                            input logic upper);
    logic [7:0] letter_base;
    letter_base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + 8'(d);
    end
    return letter_base + 8'(d) - 8'(DIGIT_TEN);
  endfunction

endpackage

// File: hw/rtl/ira_divider.sv
// Restoring divider that yields one quotient bit per cycle, dividing the
// magnitude by the radix. Depends on ira_pkg.

module ira_divider
  import ira_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [RADIX_W-1:0]    remainder
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      bits_r, bits_nxt;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [RADIX_W-1:0]    r_r, r_nxt;
  logic [RADIX_W:0]      trial;
  logic [RADIX_W:0]      diff;
  logic                  fits;

  assign trial = {r_r, q_r[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bits_nxt = bits_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    if (start) begin
      busy_nxt = 1'b1;
      bits_nxt = CNT_W'(VALUE_BITS);
      q_nxt    = dividend;
      r_nxt    = '0;
    end else if (busy_r) begin
      q_nxt    = {q_r[VALUE_BITS-2:0], fits};
      r_nxt    = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      bits_nxt = bits_r - CNT_W'(1);
      if (bits_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bits_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      bits_r <= bits_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = r_r;

endmodule

// File: hw/rtl/ira_digit_ram.sv
// Digit store: one write port and one registered read port, holding digit
// values least significant first. Depends on ira_pkg.

module ira_digit_ram
  import ira_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [RADIX_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [RADIX_W-1:0] rd_data
);

  logic [RADIX_W-1:0] mem [VALUE_BITS];
  logic [RADIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/int_to_radix_ascii.sv
// Top level of the integer to radix ASCII converter: sequencer, divider
// and digit store. Depends on ira_pkg, ira_divider and ira_digit_ram.
//
// Usage: the input channel (in_valid, in_ready, in_data) takes one beat
// holding a signed value, a radix and a letter-case flag. A radix outside
// 2 to 36 is treated as ten. The output channel (out_valid, out_ready,
// out_data) gives one beat per character, most significant first, with a
// leading minus sign for negative values and last set on the final one.
// Zero gives the single character '0'.
// Timing: each digit costs one pass of the shared one-bit-per-cycle divider,
// which takes one divide step per value bit plus a start and a write-back.
// Emission then passes each digit character through a read state and a
// load state, as the digit store has a registered read port, and a minus
// sign through a state of its own.
// in_ready is high only while the sequencer is idle; the final character may
// still sit in the output register while the next beat is accepted.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits. Reset returns the sequencer to idle and empties the
// output register; the digit store is not cleared.

module int_to_radix_ascii
  import ira_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_WAIT  = 6'b000100,
    S_SIGN  = 6'b001000,
    S_READ  = 6'b010000,
    S_LOAD  = 6'b100000
  } seq_state_t;

  seq_state_t            state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic                  neg_r, neg_nxt;
  logic                  upper_r, upper_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_r, out_nxt;

  logic                  accept;
  logic                  out_free;
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;
  logic                  ram_wr_en;
  logic                  ram_rd_en;
  logic [RADIX_W-1:0]    ram_rd_data;
  logic                  in_neg;
  logic [RADIX_W-1:0]    in_radix;
  logic                  load_last;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_neg   = in_data.value[VALUE_BITS-1];
  assign in_radix = (in_data.base < MIN_RADIX || in_data.base > MAX_RADIX) ?
                    DEFAULT_RADIX : in_data.base;

  assign div_start = (state_r == S_START);
  assign ram_wr_en = (state_r == S_WAIT) && div_done;
  assign ram_rd_en = (state_r == S_READ);
  assign load_last = (state_r == S_LOAD) && out_free && (idx_r == '0);

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    radix_nxt     = radix_r;
    neg_nxt       = neg_r;
    upper_nxt     = upper_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mag_nxt   = in_neg ? (~in_data.value + VALUE_BITS'(1)) : in_data.value;
          radix_nxt = in_radix;
          neg_nxt   = in_neg;
          upper_nxt = in_data.upper_case;
          cnt_nxt   = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          mag_nxt = div_quot;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (div_quot == '0) begin
            idx_nxt   = cnt_r[IDX_W-1:0];
            state_nxt = neg_r ? S_SIGN : S_READ;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_nxt.char_code = CHAR_MINUS;
          out_nxt.last      = 1'b0;
          state_nxt         = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_nxt.char_code = digit_char(ram_rd_data, upper_r);
          out_nxt.last      = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      upper_r     <= 1'b0;
      radix_r     <= DEFAULT_RADIX;
      mag_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
      upper_r     <= upper_nxt;
      radix_r     <= radix_nxt;
      mag_r       <= mag_nxt;
    end
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  ira_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag_r),
    .divisor   (radix_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  ira_digit_ram u_digit_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (div_rem),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_START))
    else $error("Accepted beat did not start a division.");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (div_rem < radix_r))
    else $error("Stored digit is not below the radix.");

  a_digit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(VALUE_BITS))
    else $error("Digit count exceeds the value width.");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    load_last |=> (state_r == S_IDLE) && out_valid && out_data.last)
    else $error("Final character did not return the sequencer to idle.");

  a_wait_has_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_START) |=> !div_done)
    else $error("Divider finished in the cycle after its start.");

endmodule
